// ===== rtl/gvt_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package gvt_pkg;

   localparam int VERTICES    = 32;
   localparam int STACK_DEPTH = 1024;
   localparam int VW          = 5;                     // vertex number width
   localparam int AW          = $clog2(STACK_DEPTH);   // work store address
   localparam int CW          = AW + 1;                // occupancy count

   typedef enum logic [2:0] {
      CMD_ADD_VERTEX = 3'd0,
      CMD_ADD_EDGE   = 3'd1,
      CMD_BFS        = 3'd2,
      CMD_DFS        = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic graph_we;    // apply a graph edit from the request ports
      logic latch_req;   // capture walk start, stop and mode
      logic init;        // clear walk state, push start vertex
      logic refuse_out;  // load refusal result
      logic pop;         // read work store, move pointers
      logic take_u;      // capture popped vertex, mark visited, build mask
      logic emit_new;    // move pending result out, pend the new visit
      logic push_one;    // push one neighbor from the mask
      logic final_out;   // load pending result marked last
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic usable;
      logic tail_zero;
      logic new_vertex;
      logic is_stop;
      logic mask_zero;
      logic out_free;
      logic pending_valid;
   } sts_type;

endpackage

// ===== rtl/graph_bfs_dfs_traversal.sv =====
// Top level of the graph store with breadth-first and depth-first walks.
// Holds up to 32 vertices as a presence bitmap and an adjacency bit matrix.
// Add vertex, add edge and clear are applied at once, with no stall. A walk emits one
// response per newly visited vertex, the final one marked last; a refused
// walk emits a single response with visit_valid low. Walk time is set by the
// sequencer loop over the 1024-entry work store: each pop reads a vertex,
// marks it visited, pends it as a result if newly visited, checks it against
// the stop vertex and then pushes its unvisited neighbors one at a time; a
// walk grows longer with many neighbors, repeated pushes
// or response stalls. One request is worked at a time;
// req_stall stays high until the walk's last response is in the output
// register, which decouples the response side.
module graph_bfs_dfs_traversal (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_cmd,
   input  logic [gvt_pkg::VW-1:0] req_vertex_a,
   input  logic [gvt_pkg::VW-1:0] req_vertex_b,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [gvt_pkg::VW-1:0] rsp_visit_vertex,
   output logic                   rsp_visit_valid,
   output logic                   rsp_stop_reached,
   output logic                   rsp_stack_overflow,
   output logic                   rsp_last
);

   gvt_pkg::ctl_type ctl;
   gvt_pkg::sts_type sts;

   gvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   gvt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_vertex_a       (req_vertex_a),
      .req_vertex_b       (req_vertex_b),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visit_vertex   (rsp_visit_vertex),
      .rsp_visit_valid    (rsp_visit_valid),
      .rsp_stop_reached   (rsp_stop_reached),
      .rsp_stack_overflow (rsp_stack_overflow),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== rtl/gvt_ctrl.sv =====
// Walk sequencer: state machine that drives the traversal datapath.
module gvt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_cmd,
   output logic             req_stall,
   input  gvt_pkg::sts_type sts,
   output gvt_pkg::ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_REFUSE, ST_POP, ST_RD, ST_NEWV, ST_CHK, ST_SCAN, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == gvt_pkg::CMD_BFS || req_cmd == gvt_pkg::CMD_DFS) begin
                  ctl.latch_req = 1'b1;
                  state_in      = ST_START;
               end else begin
                  ctl.graph_we = 1'b1;
               end
            end
         end
         ST_START: begin
            if (sts.usable) begin
               ctl.init = 1'b1;
               state_in = ST_POP;
            end else begin
               state_in = ST_REFUSE;
            end
         end
         ST_REFUSE: begin
            if (sts.out_free) begin
               ctl.refuse_out = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_POP: begin
            if (sts.tail_zero) begin
               state_in = ST_FIN;
            end else begin
               ctl.pop  = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ctl.take_u = 1'b1;
            state_in   = sts.new_vertex ? ST_NEWV : ST_CHK;
         end
         ST_NEWV: begin
            if (!sts.pending_valid || sts.out_free) begin
               ctl.emit_new = 1'b1;
               state_in     = ST_CHK;
            end
         end
         ST_CHK: begin
            state_in = sts.is_stop ? ST_FIN : ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.mask_zero) begin
               state_in = ST_POP;
            end else begin
               ctl.push_one = 1'b1;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               ctl.final_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/gvt_datapath.sv =====
// Graph store, work store, walk registers and result register.
module gvt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_cmd,
   input  logic [gvt_pkg::VW-1:0] req_vertex_a,
   input  logic [gvt_pkg::VW-1:0] req_vertex_b,
   input  gvt_pkg::ctl_type       ctl,
   output gvt_pkg::sts_type       sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [gvt_pkg::VW-1:0] rsp_visit_vertex,
   output logic                   rsp_visit_valid,
   output logic                   rsp_stop_reached,
   output logic                   rsp_stack_overflow,
   output logic                   rsp_last
);

   localparam int V  = gvt_pkg::VERTICES;
   localparam int VW = gvt_pkg::VW;
   localparam int AW = gvt_pkg::AW;
   localparam int CW = gvt_pkg::CW;

   logic [V-1:0]  present_ff;
   logic [V-1:0]  adj_ff [V];
   logic [V-1:0]  visited_ff;
   logic [V-1:0]  mask_ff;
   logic [VW-1:0] work_mem [gvt_pkg::STACK_DEPTH];
   logic [VW-1:0] rd_data_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] tail_ff;
   logic          ovf_ff;
   logic [VW-1:0] start_ff, stop_ff, u_ff;
   logic          fifo_ff;
   logic          pend_valid_ff, pend_stop_ff, pend_ovf_ff;
   logic [VW-1:0] pend_vertex_ff;
   logic          out_valid_ff, out_vvalid_ff, out_stop_ff, out_ovf_ff, out_last_ff;
   logic [VW-1:0] out_vertex_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [VW-1:0] mem_wdata;
   logic [VW-1:0] sel_lo, sel_hi, sel;
   logic          store_full;
   logic          out_free;

   // neighbor pick: lowest for breadth-first, highest for depth-first
   always_comb begin
      sel_lo = '0;
      sel_hi = '0;
      for (int i = V - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel_lo = VW'(i);
      end
      for (int i = 0; i < V; i++) begin
         if (mask_ff[i]) sel_hi = VW'(i);
      end
   end
   assign sel        = fifo_ff ? sel_lo : sel_hi;
   assign store_full = (tail_ff == CW'(gvt_pkg::STACK_DEPTH));
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = sel;
      if (ctl.init) begin
         mem_we    = 1'b1;
         mem_wdata = start_ff;
      end else if (ctl.push_one && !store_full) begin
         mem_we    = 1'b1;
         mem_waddr = fifo_ff ? AW'(head_ff + tail_ff[AW-1:0]) : tail_ff[AW-1:0];
      end
   end
   assign mem_raddr = fifo_ff ? head_ff : AW'(tail_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (mem_we) work_mem[mem_waddr] <= mem_wdata;
      if (ctl.pop) rd_data_ff <= work_mem[mem_raddr];
   end

   // graph store
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         for (int i = 0; i < V; i++) adj_ff[i] <= '0;
      end else if (ctl.graph_we) begin
         case (req_cmd)
            gvt_pkg::CMD_ADD_VERTEX: present_ff[req_vertex_a] <= 1'b1;
            gvt_pkg::CMD_ADD_EDGE: begin
               adj_ff[req_vertex_a][req_vertex_b] <= 1'b1;
               adj_ff[req_vertex_b][req_vertex_a] <= 1'b1;
            end
            gvt_pkg::CMD_CLEAR: begin
               present_ff <= '0;
               for (int i = 0; i < V; i++) adj_ff[i] <= '0;
            end
            default: ;
         endcase
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         ovf_ff        <= 1'b0;
         visited_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (ctl.init) begin
            head_ff       <= '0;
            tail_ff       <= CW'(1);
            ovf_ff        <= 1'b0;
            visited_ff    <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (ctl.pop) begin
            if (fifo_ff) head_ff <= head_ff + AW'(1);
            tail_ff <= tail_ff - CW'(1);
         end
         if (ctl.take_u) begin
            visited_ff[rd_data_ff] <= 1'b1;
         end
         if (ctl.push_one) begin
            if (store_full) ovf_ff <= 1'b1;
            else tail_ff <= tail_ff + CW'(1);
         end
         if (ctl.emit_new) pend_valid_ff <= 1'b1;
         if (ctl.final_out) pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         start_ff <= req_vertex_a;
         stop_ff  <= req_vertex_b;
         fifo_ff  <= (req_cmd == gvt_pkg::CMD_BFS);
      end
      if (ctl.take_u) begin
         u_ff    <= rd_data_ff;
         mask_ff <= adj_ff[rd_data_ff] & ~(visited_ff | (V'(1) << rd_data_ff));
      end else if (ctl.push_one) begin
         mask_ff[sel] <= 1'b0;
      end
      if (ctl.emit_new) begin
         pend_vertex_ff <= u_ff;
         pend_stop_ff   <= (u_ff == stop_ff);
         pend_ovf_ff    <= ovf_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.refuse_out || ctl.final_out || (ctl.emit_new && pend_valid_ff)) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.refuse_out) begin
         out_vertex_ff <= start_ff;
         out_vvalid_ff <= 1'b0;
         out_stop_ff   <= 1'b0;
         out_ovf_ff    <= 1'b0;
         out_last_ff   <= 1'b1;
      end else if (ctl.final_out || (ctl.emit_new && pend_valid_ff)) begin
         out_vertex_ff <= pend_vertex_ff;
         out_vvalid_ff <= 1'b1;
         out_stop_ff   <= pend_stop_ff;
         out_ovf_ff    <= ctl.final_out ? ovf_ff : pend_ovf_ff;
         out_last_ff   <= ctl.final_out;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_visit_vertex   = out_vertex_ff;
   assign rsp_visit_valid    = out_vvalid_ff;
   assign rsp_stop_reached   = out_stop_ff;
   assign rsp_stack_overflow = out_ovf_ff;
   assign rsp_last           = out_last_ff;

   always_comb begin
      sts.usable        = fifo_ff ? present_ff[start_ff] : (adj_ff[start_ff] != '0);
      sts.tail_zero     = (tail_ff == '0);
      sts.new_vertex    = !visited_ff[rd_data_ff];
      sts.is_stop       = (u_ff == stop_ff);
      sts.mask_zero     = (mask_ff == '0);
      sts.out_free      = out_free;
      sts.pending_valid = pend_valid_ff;
   end

`ifndef SYNTHESIS
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= CW'(gvt_pkg::STACK_DEPTH))
      else $error("work store occupancy above depth");
   a_visit_marked: assert property (@(posedge clock) disable iff (reset)
      ctl.take_u |=> visited_ff[u_ff])
      else $error("popped vertex not marked visited");
   a_refusal_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_vvalid_ff) |-> out_last_ff)
      else $error("refusal result not marked last");
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit_new && pend_valid_ff) |-> out_free)
      else $error("result register overwritten");
`endif

endmodule

// ===== test/graph_bfs_dfs_traversal_tb.sv =====
// Self-checking testbench for the graph store with breadth-first and depth-first walks.
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_tb;

   // command codes the block must ignore
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake on either side

   typedef struct {
      logic [2:0]             cmd;
      logic [gvt_pkg::VW-1:0] va;
      logic [gvt_pkg::VW-1:0] vb;
   } request_type;

   typedef struct {
      logic [gvt_pkg::VW-1:0] vertex;
      logic                   valid;
      logic                   stop;
      logic                   ovf;
      logic                   last;
   } visit_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [2:0]             req_cmd = '0;
   logic [gvt_pkg::VW-1:0] req_vertex_a = '0;
   logic [gvt_pkg::VW-1:0] req_vertex_b = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [gvt_pkg::VW-1:0] rsp_visit_vertex;
   logic                   rsp_visit_valid;
   logic                   rsp_stop_reached;
   logic                   rsp_stack_overflow;
   logic                   rsp_last;

   graph_bfs_dfs_traversal dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // graph mirror and walk scratch state
   logic [gvt_pkg::VERTICES-1:0] graph_present;
   logic [gvt_pkg::VERTICES-1:0] graph_adj [gvt_pkg::VERTICES];
   logic [gvt_pkg::VW-1:0]       walk_store [gvt_pkg::STACK_DEPTH];
   int                           walk_head;
   int                           walk_count;

   request_type pending_q [$];
   visit_type   visit_q [$];
   int          total_items;
   int          issued;
   int          errors = 0;
   logic        req_fire = 1'b0;

   task automatic walk_push(input logic [gvt_pkg::VW-1:0] v, input bit fifo, inout bit ovf);
      int idx;
      if (walk_count >= gvt_pkg::STACK_DEPTH) begin
         ovf = 1'b1;
      end else begin
         idx = fifo ? (walk_head + walk_count) % gvt_pkg::STACK_DEPTH : walk_count;
         walk_store[idx] = v;
         walk_count++;
      end
   endtask

   // Runs one command against the mirror and queues the visits it produces.
   task automatic predict_visits(input request_type r);
      visit_type                    walk_visits [$];
      visit_type                    one;
      logic [gvt_pkg::VERTICES-1:0] seen;
      logic [gvt_pkg::VW-1:0]       u;
      bit                           fifo;
      bit                           ovf;
      bit                           usable;
      int                           w;
      case (r.cmd)
         gvt_pkg::CMD_ADD_VERTEX: graph_present[r.va] = 1'b1;
         gvt_pkg::CMD_ADD_EDGE: begin
            graph_adj[r.va][r.vb] = 1'b1;
            graph_adj[r.vb][r.va] = 1'b1;
         end
         gvt_pkg::CMD_CLEAR: begin
            graph_present = '0;
            foreach (graph_adj[i]) graph_adj[i] = '0;
         end
         gvt_pkg::CMD_BFS, gvt_pkg::CMD_DFS: begin
            fifo = (r.cmd == gvt_pkg::CMD_BFS);
            usable = fifo ? graph_present[r.va] : (graph_adj[r.va] != '0);
            if (!usable) begin
               one = '{r.va, 1'b0, 1'b0, 1'b0, 1'b1};
               visit_q.push_back(one);
            end else begin
               ovf = 1'b0;
               seen = '0;
               walk_head = 0;
               walk_count = 0;
               walk_push(r.va, fifo, ovf);
               while (walk_count != 0) begin
                  if (fifo) begin
                     u = walk_store[walk_head];
                     walk_head = (walk_head + 1) % gvt_pkg::STACK_DEPTH;
                  end else begin
                     u = walk_store[walk_count-1];
                  end
                  walk_count--;
                  if (!seen[u]) begin
                     seen[u] = 1'b1;
                     one = '{u, 1'b1, u == r.vb, ovf, 1'b0};
                     walk_visits.push_back(one);
                  end
                  if (u == r.vb) break;
                  for (int i = 0; i < gvt_pkg::VERTICES; i++) begin
                     w = fifo ? i : gvt_pkg::VERTICES - 1 - i;
                     if (graph_adj[u][w] && !seen[w])
                        walk_push(w[gvt_pkg::VW-1:0], fifo, ovf);
                  end
               end
               walk_visits[$].ovf = ovf;
               walk_visits[$].last = 1'b1;
               foreach (walk_visits[i]) visit_q.push_back(walk_visits[i]);
            end
         end
         default: ;
      endcase
   endtask

   function automatic request_type mk(logic [2:0] c, int a, int b);
      request_type r;
      r.cmd = c;
      r.va = a[gvt_pkg::VW-1:0];
      r.vb = b[gvt_pkg::VW-1:0];
      return r;
   endfunction

   // Sender/receiver idle percentages for the three phases.
   function automatic int sender_idle_pct();
      if (issued < total_items / 3) return 27;
      if (issued < 2 * total_items / 3) return 84;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (issued < total_items / 3) return 84;
      if (issued < 2 * total_items / 3) return 27;
      return 0;
   endfunction

   // Request and response-stall driver: new payload only after the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
         if (!req_valid || req_fire) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               req_valid    <= 1'b1;
               req_cmd      <= pending_q[0].cmd;
               req_vertex_a <= pending_q[0].va;
               req_vertex_b <= pending_q[0].vb;
               void'(pending_q.pop_front());
               issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Accepted requests feed the predictor; accepted responses are checked.
   always @(posedge clock) begin
      visit_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         predict_visits(mk(req_cmd, req_vertex_a, req_vertex_b));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (visit_q.size() == 0) begin
            $display("%0t: unexpected response vertex %0d valid %b last %b", $time,
                     rsp_visit_vertex, rsp_visit_valid, rsp_last);
            errors++;
         end else begin
            want = visit_q.pop_front();
            if (rsp_visit_vertex !== want.vertex || rsp_visit_valid !== want.valid ||
                rsp_stop_reached !== want.stop || rsp_stack_overflow !== want.ovf ||
                rsp_last !== want.last) begin
               $display("%0t: mismatch expected v=%0d val=%b stop=%b ovf=%b last=%b",
                        $time, want.vertex, want.valid, want.stop, want.ovf, want.last);
               $display("%0t:          actual   v=%0d val=%b stop=%b ovf=%b last=%b",
                        $time, rsp_visit_vertex, rsp_visit_valid, rsp_stop_reached,
                        rsp_stack_overflow, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog: a stuck handshake on both sides ends the run.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int nv;
      int ne;
      int pool;
      int a;
      graph_present = '0;
      foreach (graph_adj[i]) graph_adj[i] = '0;

      // directed: refusals on an empty graph, extremes, spare codes, duplicates
      pending_q.push_back(mk(gvt_pkg::CMD_BFS, 0, 31));
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 31, 0));
      pending_q.push_back(mk(CMD_SPARE_5, 31, 31));
      pending_q.push_back(mk(CMD_SPARE_6, 0, 0));
      pending_q.push_back(mk(CMD_SPARE_7, 21, 10));
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_VERTEX, 0, 0));
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_VERTEX, 31, 0));
      pending_q.push_back(mk(gvt_pkg::CMD_BFS, 0, 31));       // present, no edges
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 0, 31));       // no edge: refused
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, 0, 31));
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, 31, 0));  // already there
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, 5, 5));   // self edge, absent vertex
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, 31, 17));
      pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, 0, 10));
      pending_q.push_back(mk(gvt_pkg::CMD_BFS, 0, 17));       // stop reached
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 0, 3));        // stop never reached
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 5, 5));        // start equals stop
      pending_q.push_back(mk(gvt_pkg::CMD_BFS, 5, 0));        // edge but not present
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 17, 10));
      pending_q.push_back(mk(gvt_pkg::CMD_CLEAR, 0, 0));
      pending_q.push_back(mk(gvt_pkg::CMD_BFS, 0, 31));
      pending_q.push_back(mk(gvt_pkg::CMD_DFS, 0, 31));

      // random: build a graph on a vertex pool, then walk it; some noise
      while (pending_q.size() < 262) begin
         pool = $urandom_range(3) == 0 ? 31 : $urandom_range(30, 4);
         pending_q.push_back(mk(gvt_pkg::CMD_CLEAR, $urandom, $urandom));
         nv = $urandom_range(10, 3);
         ne = $urandom_range(16, 2);
         for (int i = 0; i < nv; i++)
            pending_q.push_back(mk(gvt_pkg::CMD_ADD_VERTEX, $urandom_range(pool), $urandom));
         for (int i = 0; i < ne; i++)
            pending_q.push_back(mk(gvt_pkg::CMD_ADD_EDGE, $urandom_range(pool),
                                   $urandom_range(pool)));
         for (int i = 0; i < 4; i++) begin
            a = $urandom_range(pool);
            pending_q.push_back(mk($urandom_range(1) ? gvt_pkg::CMD_BFS : gvt_pkg::CMD_DFS,
                                   a, $urandom_range(3) == 0 ? a : $urandom_range(31)));
         end
         if ($urandom_range(3) == 0)
            pending_q.push_back(mk(3'($urandom_range(7)), $urandom, $urandom));
      end
      total_items = pending_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0);
      @(posedge clock);
      wait (!req_valid && visit_q.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && visit_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
